@@ rtl/epc_pkg.sv @@
`timescale 1ns / 1ps

package epc_pkg;

  localparam int unsigned NSTG = 9;

  localparam int unsigned SECS_W  = 31;
  localparam int unsigned TDATA_IN_W  = 32;
  localparam int unsigned TDATA_OUT_W = 40;

  localparam int unsigned DAYS_W  = 15;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned YEAR_W  = 11;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned WDAY_W  = 3;

  // seconds / 86400 == (seconds >> 7) / 675
  localparam int unsigned LO_W    = 7;
  localparam int unsigned HI_W    = SECS_W - LO_W;
  localparam int unsigned DIV_HI  = 675;
  localparam int unsigned DIV_HI_W = 10;
  localparam int unsigned M1      = 25451658;
  localparam int unsigned M1_W    = 25;
  localparam int unsigned K1      = 34;
  localparam int unsigned PROD1_W = HI_W + M1_W;
  localparam int unsigned REM1_W  = 11;

  // days since 1969-01-01 / 1461
  localparam int unsigned CYC_DAYS = 1461;
  localparam int unsigned M2       = 45933;
  localparam int unsigned M2_W     = 16;
  localparam int unsigned K2       = 26;
  localparam int unsigned PROD2_W  = DAYS_W + M2_W;
  localparam int unsigned CYC_W    = 5;
  localparam int unsigned REM2_W   = 12;
  localparam int unsigned REMC_W   = 11;

  localparam int unsigned YEAR_DAYS  = 365;
  localparam int unsigned YEAR_BASE  = 1969;
  localparam int unsigned EPOCH_WDAY = 4;

  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned HOURS         = 24;
  localparam int unsigned MINS          = 60;
  localparam int unsigned MONTHS        = 12;
  localparam int unsigned FEB_IDX       = 1;

  typedef logic [NSTG-1:0]  stage_en_t;
  typedef logic [DOY_W-1:0] doy_t;

  localparam doy_t MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

@@ rtl/epc_split.sv @@
`timescale 1ns / 1ps

module epc_split (
  input  logic                        clk,
  input  epc_pkg::stage_en_t          en,
  input  logic [epc_pkg::SECS_W-1:0]  secs,
  output logic [epc_pkg::DAYS_W-1:0]  days,
  output logic [epc_pkg::SOD_W-1:0]   sod
);

  localparam int unsigned HW  = epc_pkg::HI_W;
  localparam int unsigned LW  = epc_pkg::LO_W;
  localparam int unsigned PW  = epc_pkg::PROD1_W;
  localparam int unsigned DW  = epc_pkg::DAYS_W;
  localparam int unsigned MW  = epc_pkg::DAYS_W + epc_pkg::DIV_HI_W;
  localparam int unsigned RW  = epc_pkg::REM1_W;
  localparam int unsigned SW  = epc_pkg::SOD_W;
  localparam int unsigned K   = epc_pkg::K1;

  logic [HW-1:0] x0_r, x1_r;
  logic [LW-1:0] lo0_r, lo1_r;
  logic [PW-1:0] p0_r;
  logic [DW-1:0] q1_r;
  logic [MW-1:0] m1_r;
  logic [DW-1:0] q0_nxt;
  logic [MW-1:0] diff_nxt;
  logic [RW-1:0] r0_nxt;
  logic          fix_nxt;
  logic [DW-1:0] days_r;
  logic [SW-1:0] sod_r;
  logic [DW-1:0] days_nxt;
  logic [RW-1:0] rem_nxt;

  assign q0_nxt   = p0_r[K+DW-1:K];
  assign diff_nxt = MW'(x1_r) - m1_r;
  assign r0_nxt   = diff_nxt[RW-1:0];
  assign fix_nxt  = (r0_nxt >= RW'(epc_pkg::DIV_HI));
  assign days_nxt = fix_nxt ? q1_r + DW'(1) : q1_r;
  assign rem_nxt  = fix_nxt ? r0_nxt - RW'(epc_pkg::DIV_HI) : r0_nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r  <= secs[epc_pkg::SECS_W-1:LW];
      lo0_r <= secs[LW-1:0];
      p0_r  <= PW'(secs[epc_pkg::SECS_W-1:LW]) * PW'(epc_pkg::M1);
    end
    if (en[1]) begin
      x1_r  <= x0_r;
      lo1_r <= lo0_r;
      q1_r  <= q0_nxt;
      m1_r  <= MW'(q0_nxt) * MW'(epc_pkg::DIV_HI);
    end
    if (en[2]) begin
      days_r <= days_nxt;
      sod_r  <= {rem_nxt[SW-LW-1:0], lo1_r};
    end
  end

  assign days = days_r;
  assign sod  = sod_r;

endmodule

@@ rtl/epc_date.sv @@
`timescale 1ns / 1ps

module epc_date (
  input  logic                         clk,
  input  epc_pkg::stage_en_t           en,
  input  logic [epc_pkg::DAYS_W-1:0]   days,
  output logic [epc_pkg::YEAR_W-1:0]   year,
  output logic [epc_pkg::MONTH_W-1:0]  month,
  output logic [epc_pkg::DAY_W-1:0]    day_of_month,
  output logic [epc_pkg::WDAY_W-1:0]   weekday
);

  localparam int unsigned DW  = epc_pkg::DAYS_W;
  localparam int unsigned PW  = epc_pkg::PROD2_W;
  localparam int unsigned CW  = epc_pkg::CYC_W;
  localparam int unsigned RW  = epc_pkg::REM2_W;
  localparam int unsigned CRW = epc_pkg::REMC_W;
  localparam int unsigned YW  = epc_pkg::YEAR_W;
  localparam int unsigned OW  = epc_pkg::DOY_W;
  localparam int unsigned MW  = epc_pkg::MONTH_W;
  localparam int unsigned WW  = epc_pkg::WDAY_W;
  localparam int unsigned NM  = epc_pkg::MONTHS;
  localparam int unsigned K   = epc_pkg::K2;
  localparam int unsigned YD  = epc_pkg::YEAR_DAYS;
  localparam int unsigned DAY_W_L = epc_pkg::DAY_W;

  // weekday: 8 is 1 modulo 7, so fold octal digits
  logic [DW-1:0] wn_nxt;
  logic [5:0]    ws_nxt;
  logic [3:0]    wt_nxt;
  logic [WW-1:0] wd_nxt;

  assign wn_nxt = days + DW'(epc_pkg::EPOCH_WDAY);
  assign ws_nxt = 6'(wn_nxt[2:0]) + 6'(wn_nxt[5:3]) + 6'(wn_nxt[8:6])
                + 6'(wn_nxt[11:9]) + 6'(wn_nxt[14:12]);
  assign wt_nxt = 4'(ws_nxt[5:3]) + 4'(ws_nxt[2:0]);
  assign wd_nxt = (wt_nxt >= 4'd7) ? WW'(wt_nxt - 4'd7) : WW'(wt_nxt);

  logic [DW-1:0] dd3_r, dd4_r;
  logic [PW-1:0] p3_r;
  logic [WW-1:0] wd3_r, wd4_r, wd5_r, wd6_r, wd7_r, wd8_r;
  logic [CW-1:0] c4_r, c5_r;
  logic [DW-1:0] m4_r;
  logic [CW-1:0] c_nxt;
  logic [DW-1:0] dd_nxt;
  logic [RW-1:0] r0_nxt;
  logic          cfix_nxt;
  logic [CRW-1:0] r5_r;
  logic [CRW-1:0] r_nxt;

  assign dd_nxt   = days + DW'(epc_pkg::YEAR_DAYS);
  assign c_nxt    = p3_r[K+CW-1:K];
  assign r0_nxt   = RW'(dd4_r - m4_r);
  assign cfix_nxt = (r0_nxt >= RW'(epc_pkg::CYC_DAYS));
  assign r_nxt    = cfix_nxt ? CRW'(r0_nxt - RW'(epc_pkg::CYC_DAYS)) : CRW'(r0_nxt);

  logic [1:0]    yi_nxt;
  logic [YW-1:0] year6_r, year7_r, year8_r;
  logic [OW-1:0] doy6_r, doy7_r;
  logic          leap6_r, leap7_r;
  logic [CRW-1:0] yoff_nxt;

  assign yi_nxt = 2'(r5_r >= CRW'(YD)) + 2'(r5_r >= CRW'(2 * YD))
                + 2'(r5_r >= CRW'(3 * YD));
  assign yoff_nxt = CRW'(yi_nxt) * CRW'(YD);

  logic [NM-2:0] mge_nxt;
  logic [MW-1:0] month_nxt;
  logic [MW-1:0] month7_r, month8_r;
  logic [OW-1:0] mstart_nxt;
  logic [OW-1:0] day_nxt;
  logic [DAY_W_L-1:0] day8_r;

  always_comb begin
    for (int m = 1; m < NM; m++) begin
      mge_nxt[m-1] = doy6_r >= (epc_pkg::MONTH_START[m]
                    + OW'(leap6_r && (m > epc_pkg::FEB_IDX)));
    end
  end

  assign month_nxt  = MW'($countones(mge_nxt)) + MW'(1);
  assign mstart_nxt = epc_pkg::MONTH_START[month7_r - MW'(1)]
                    + OW'(leap7_r && (month7_r > MW'(epc_pkg::FEB_IDX + 1)));
  assign day_nxt    = doy7_r - mstart_nxt + OW'(1);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dd3_r <= dd_nxt;
      p3_r  <= PW'(dd_nxt) * PW'(epc_pkg::M2);
      wd3_r <= wd_nxt;
    end
    if (en[4]) begin
      dd4_r <= dd3_r;
      c4_r  <= c_nxt;
      m4_r  <= DW'(c_nxt) * DW'(epc_pkg::CYC_DAYS);
      wd4_r <= wd3_r;
    end
    if (en[5]) begin
      c5_r  <= cfix_nxt ? c4_r + CW'(1) : c4_r;
      r5_r  <= r_nxt;
      wd5_r <= wd4_r;
    end
    if (en[6]) begin
      year6_r <= YW'(epc_pkg::YEAR_BASE) + (YW'(c5_r) << 2) + YW'(yi_nxt);
      doy6_r  <= OW'(r5_r - yoff_nxt);
      leap6_r <= (yi_nxt == 2'd3);
      wd6_r   <= wd5_r;
    end
    if (en[7]) begin
      year7_r  <= year6_r;
      doy7_r   <= doy6_r;
      leap7_r  <= leap6_r;
      month7_r <= month_nxt;
      wd7_r    <= wd6_r;
    end
    if (en[8]) begin
      year8_r  <= year7_r;
      month8_r <= month7_r;
      day8_r   <= day_nxt[DAY_W_L-1:0];
      wd8_r    <= wd7_r;
    end
  end

  assign year         = year8_r;
  assign month        = month8_r;
  assign day_of_month = day8_r;
  assign weekday      = wd8_r;

endmodule

@@ rtl/epc_tod.sv @@
`timescale 1ns / 1ps

module epc_tod (
  input  logic                        clk,
  input  epc_pkg::stage_en_t          en,
  input  logic [epc_pkg::SOD_W-1:0]   sod,
  output logic [epc_pkg::HOUR_W-1:0]  hour,
  output logic [epc_pkg::MIN_W-1:0]   minute,
  output logic [epc_pkg::SEC_W-1:0]   second
);

  localparam int unsigned SW  = epc_pkg::SOD_W;
  localparam int unsigned HW  = epc_pkg::HOUR_W;
  localparam int unsigned MW  = epc_pkg::MIN_W;
  localparam int unsigned CW  = epc_pkg::SEC_W;
  localparam int unsigned RW  = 12;
  localparam int unsigned NH  = epc_pkg::HOURS;
  localparam int unsigned NM  = epc_pkg::MINS;

  logic [NH-2:0] hge_nxt;
  logic [NM-2:0] mge_nxt;
  logic [SW-1:0] sod3_r;
  logic [HW-1:0] hour3_r, hour4_r, hour5_r, hour6_r, hour7_r, hour8_r;
  logic [RW-1:0] rh4_r, rh5_r;
  logic [MW-1:0] min5_r, min6_r, min7_r, min8_r;
  logic [CW-1:0] sec6_r, sec7_r, sec8_r;
  logic [SW-1:0] hsub_nxt;
  logic [RW-1:0] msub_nxt;

  always_comb begin
    for (int h = 1; h < NH; h++) begin
      hge_nxt[h-1] = sod >= SW'(h * epc_pkg::SECS_PER_HOUR);
    end
    for (int m = 1; m < NM; m++) begin
      mge_nxt[m-1] = rh4_r >= RW'(m * epc_pkg::SECS_PER_MIN);
    end
  end

  assign hsub_nxt = SW'(hour3_r) * SW'(epc_pkg::SECS_PER_HOUR);
  assign msub_nxt = RW'(min5_r) * RW'(epc_pkg::SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sod3_r  <= sod;
      hour3_r <= HW'($countones(hge_nxt));
    end
    if (en[4]) begin
      rh4_r   <= RW'(sod3_r - hsub_nxt);
      hour4_r <= hour3_r;
    end
    if (en[5]) begin
      rh5_r   <= rh4_r;
      min5_r  <= MW'($countones(mge_nxt));
      hour5_r <= hour4_r;
    end
    if (en[6]) begin
      sec6_r  <= CW'(rh5_r - msub_nxt);
      min6_r  <= min5_r;
      hour6_r <= hour5_r;
    end
    if (en[7]) begin
      sec7_r  <= sec6_r;
      min7_r  <= min6_r;
      hour7_r <= hour6_r;
    end
    if (en[8]) begin
      sec8_r  <= sec7_r;
      min8_r  <= min7_r;
      hour8_r <= hour7_r;
    end
  end

  assign hour   = hour8_r;
  assign minute = min8_r;
  assign second = sec8_r;

endmodule

@@ rtl/epoch_seconds_to_calendar.sv @@
`timescale 1ns / 1ps

// Converts a count of seconds since 1970-01-01 00:00:00 (0 to 2^31-1) into the
// Gregorian date, time of day and weekday (0 is Sunday). A nine-stage pipeline
// takes one beat per cycle while its output is not stalled; each stage moves on
// whenever the stage after it is empty or moving, so a stalled output holds its
// beat while bubbles further up still fill. Leap seconds are not counted.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] epoch_seconds, [31] zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [10:0] year, [14:11] month, [19:15] day_of_month,
                                  // [24:20] hour, [30:25] minute, [36:31] second,
                                  // [39:37] weekday
);

  localparam int unsigned NS = epc_pkg::NSTG;

  logic [NS-1:0]      vld_r;
  epc_pkg::stage_en_t en;

  logic [epc_pkg::DAYS_W-1:0]  days;
  logic [epc_pkg::SOD_W-1:0]   sod;
  logic [epc_pkg::YEAR_W-1:0]  year;
  logic [epc_pkg::MONTH_W-1:0] month;
  logic [epc_pkg::DAY_W-1:0]   day_of_month;
  logic [epc_pkg::WDAY_W-1:0]  weekday;
  logic [epc_pkg::HOUR_W-1:0]  hour;
  logic [epc_pkg::MIN_W-1:0]   minute;
  logic [epc_pkg::SEC_W-1:0]   second;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  epc_split u_split (
    .clk  (clk),
    .en   (en),
    .secs (in_tdata[epc_pkg::SECS_W-1:0]),
    .days (days),
    .sod  (sod)
  );

  epc_date u_date (
    .clk          (clk),
    .en           (en),
    .days         (days),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

  epc_tod u_tod (
    .clk    (clk),
    .en     (en),
    .sod    (sod),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {weekday, second, minute, hour, day_of_month, month, year};

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NSTG          = epc_pkg::NSTG;
  localparam int unsigned SECS_W        = epc_pkg::SECS_W;
  localparam int unsigned TDATA_IN_W    = epc_pkg::TDATA_IN_W;
  localparam int unsigned TDATA_OUT_W   = epc_pkg::TDATA_OUT_W;
  localparam int unsigned YEAR_W        = epc_pkg::YEAR_W;
  localparam int unsigned MONTH_W       = epc_pkg::MONTH_W;
  localparam int unsigned DAY_W         = epc_pkg::DAY_W;
  localparam int unsigned HOUR_W        = epc_pkg::HOUR_W;
  localparam int unsigned MIN_W         = epc_pkg::MIN_W;
  localparam int unsigned SEC_W         = epc_pkg::SEC_W;
  localparam int unsigned WDAY_W        = epc_pkg::WDAY_W;
  localparam int unsigned EPOCH_WDAY    = epc_pkg::EPOCH_WDAY;
  localparam int unsigned SECS_PER_HOUR = epc_pkg::SECS_PER_HOUR;
  localparam int unsigned SECS_PER_MIN  = epc_pkg::SECS_PER_MIN;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 4 * NSTG;
  localparam longint      MAX_SECS     = (longint'(1) << SECS_W) - 1;

  typedef struct packed {
    logic [WDAY_W-1:0]  weekday;
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day_of_month;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_t;

  class calendar_scoreboard;
    cal_t pending_dates[$];
    int   failures = 0;

    static function bit is_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    static function int unsigned month_days(int unsigned y, int unsigned m);
      unique case (m)
        2: begin
          return is_leap(y) ? 29 : 28;
        end
        4, 6, 9, 11: begin
          return 30;
        end
        default: begin
          return 31;
        end
      endcase
    endfunction

    function cal_t to_calendar(logic [SECS_W-1:0] secs);
      int unsigned days;
      int unsigned sod;
      int unsigned y;
      int unsigned m;
      cal_t        r;
      days = secs / SECS_PER_DAY;
      sod  = secs % SECS_PER_DAY;
      r.weekday = WDAY_W'((days + EPOCH_WDAY) % 7);
      y = 1970;
      while (days >= (is_leap(y) ? 366 : 365)) begin
        days -= is_leap(y) ? 366 : 365;
        y++;
      end
      m = 1;
      while (m < 12 && days >= month_days(y, m)) begin
        days -= month_days(y, m);
        m++;
      end
      r.year         = YEAR_W'(y);
      r.month        = MONTH_W'(m);
      r.day_of_month = DAY_W'(days + 1);
      r.hour         = HOUR_W'(sod / SECS_PER_HOUR);
      r.minute       = MIN_W'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
      r.second       = SEC_W'(sod % SECS_PER_MIN);
      return r;
    endfunction

    function void note_stamp(logic [TDATA_IN_W-1:0] word);
      pending_dates.push_back(to_calendar(word[SECS_W-1:0]));
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    endfunction

    function void check_date(logic [TDATA_OUT_W-1:0] word);
      cal_t got;
      cal_t want;
      got = cal_t'(word);
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, word);
        failures++;
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year) report("year", want.year, got.year);
      if (got.month !== want.month) report("month", want.month, got.month);
      if (got.day_of_month !== want.day_of_month)
        report("day_of_month", want.day_of_month, got.day_of_month);
      if (got.hour !== want.hour) report("hour", want.hour, got.hour);
      if (got.minute !== want.minute) report("minute", want.minute, got.minute);
      if (got.second !== want.second) report("second", want.second, got.second);
      if (got.weekday !== want.weekday) report("weekday", want.weekday, got.weekday);
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [TDATA_IN_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [TDATA_OUT_W-1:0] out_tdata;

  calendar_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  epoch_seconds_to_calendar dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_date(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic longint days_to_month(int unsigned y, int unsigned m);
    longint d;
    d = 0;
    for (int unsigned yy = 1970; yy < y; yy++) d += calendar_scoreboard::is_leap(yy) ? 366 : 365;
    for (int unsigned mm = 1; mm < m; mm++) d += calendar_scoreboard::month_days(y, mm);
    return d;
  endfunction

  function automatic logic [TDATA_IN_W-1:0] stamp_word(longint secs);
    if (secs < 0) secs = 0;
    if (secs > MAX_SECS) secs = MAX_SECS;
    return TDATA_IN_W'(secs);
  endfunction

  function automatic logic [TDATA_IN_W-1:0] pick_stamp();
    int unsigned mode;
    longint      base;
    mode = $urandom_range(99);
    if (mode < 40) begin
      return {1'b0, SECS_W'($urandom())};
    end else if (mode < 70) begin
      base = days_to_month($urandom_range(1970, 2037), $urandom_range(1, 12)) * SECS_PER_DAY;
      return stamp_word(base + longint'($urandom_range(4 * SECS_PER_DAY)) - 2 * SECS_PER_DAY);
    end else if (mode < 85) begin
      return stamp_word($urandom_range(0, 3 * SECS_PER_DAY));
    end
    return stamp_word(MAX_SECS - $urandom_range(0, 3 * SECS_PER_DAY));
  endfunction

  task automatic send_stamp(logic [TDATA_IN_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_stamp(word);
  endtask

  task automatic drain_dates();
    in_tvalid <= 1'b0;
    while (sb.pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) send_stamp(pick_stamp());
    drain_dates();
  endtask

  initial begin
    logic [TDATA_IN_W-1:0] directed[$];
    directed = {
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'h2AAA_AAAA
    };
    // year ends, leap days and the turn of 2000
    directed.push_back(stamp_word(days_to_month(1973, 1) * SECS_PER_DAY - 1));
    directed.push_back(stamp_word(days_to_month(1973, 1) * SECS_PER_DAY));
    directed.push_back(stamp_word((days_to_month(1972, 2) + 28) * SECS_PER_DAY + 43210));
    directed.push_back(stamp_word(days_to_month(1972, 3) * SECS_PER_DAY));
    directed.push_back(stamp_word(days_to_month(2000, 1) * SECS_PER_DAY - 1));
    directed.push_back(stamp_word((days_to_month(2000, 2) + 28) * SECS_PER_DAY));
    directed.push_back(stamp_word(days_to_month(2000, 3) * SECS_PER_DAY - 1));
    directed.push_back(stamp_word(days_to_month(2001, 3) * SECS_PER_DAY - 1));
    directed.push_back(stamp_word(days_to_month(2036, 3) * SECS_PER_DAY - 1));
    directed.push_back(stamp_word(days_to_month(2038, 1) * SECS_PER_DAY - 1));
    directed.push_back(stamp_word(days_to_month(2038, 1) * SECS_PER_DAY));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_stamp(directed[i]);
    drain_dates();

    run_phase(0, 0, 120);
    run_phase(80, 0, 120);
    run_phase(0, 80, 120);
    run_phase(7, 7, 120);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending_dates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
